// ===== hw/rtl/f2da_pkg.sv =====
// shared widths, codes and unit command type for the fragment address mapper
package f2da_pkg;

    // field widths
    localparam int FRAG_W     = 24;
    localparam int FIB_W      = 2;
    localparam int BLOCK_W    = FRAG_W - FIB_W;
    localparam int SLOT_W     = 5;
    localparam int OFS_W      = 16;
    localparam int LIN_W      = 40;
    localparam int CYL_W      = 22;
    localparam int ADDR_OUT_W = 24;
    localparam int SEC_W      = 8;
    localparam int CS_W       = 29;

    // geometry constants
    localparam int SECTORS_PER_FRAGMENT = 2;
    localparam int ROT_SET_SLOTS        = 32;

    // configuration registers
    localparam int BPC_W      = 12;
    localparam int BPRS_W     = 6;
    localparam int GEO_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_BPC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BPRS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HDS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRS  = 3'd4;

    // operation codes
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_LOAD      = 1'b1;

    // serial divider and multiplier widths
    localparam int DVD_W  = CS_W;
    localparam int DVS_W  = BPC_W;
    localparam int MC_W   = 16;
    localparam int MP_W   = CYL_W;
    localparam int ACC_W  = MC_W + MP_W;
    localparam int STEP_W = 5;

    // command to a serial unit
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } unit_cmd_t;

endpackage

// ===== hw/rtl/f2da_div.sv =====
// restoring divider, one quotient bit per cycle, dividend left-aligned
module f2da_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  f2da_pkg::unit_cmd_t         cmd,
    input  logic [f2da_pkg::DVD_W-1:0]  dividend,
    input  logic [f2da_pkg::DVS_W-1:0]  divisor,
    output logic [f2da_pkg::DVD_W-1:0]  quotient,
    output logic [f2da_pkg::DVS_W-1:0]  remainder,
    output logic                        done
);

    logic [f2da_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [f2da_pkg::DVD_W-1:0]  quo_reg, quo_next;
    logic [f2da_pkg::DVS_W-1:0]  rem_reg, rem_next;
    logic [f2da_pkg::DVS_W-1:0]  dvs_reg, dvs_next;
    logic [f2da_pkg::DVS_W:0]    trial;
    logic [f2da_pkg::DVS_W:0]    diff;
    logic                        fits;

    // trial subtract of the shifted partial remainder
    assign trial = {rem_reg, quo_reg[f2da_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (cmd.start)
        begin
            cnt_next = cmd.steps;
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            quo_next  = {quo_reg[f2da_pkg::DVD_W-2:0], fits};
            rem_next  = fits ? diff[f2da_pkg::DVS_W-1:0] : trial[f2da_pkg::DVS_W-1:0];
            done_next = (cnt_reg == f2da_pkg::STEP_W'(1));
        end
    end

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // shift registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ===== hw/rtl/f2da_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle, msb first
module f2da_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  f2da_pkg::unit_cmd_t         cmd,
    input  logic [f2da_pkg::MC_W-1:0]   multiplicand,
    input  logic [f2da_pkg::MP_W-1:0]   multiplier,
    output logic [f2da_pkg::ACC_W-1:0]  product,
    output logic                        done
);

    logic [f2da_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [f2da_pkg::MC_W-1:0]   mc_reg, mc_next;
    logic [f2da_pkg::MP_W-1:0]   mp_reg, mp_next;
    logic [f2da_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [f2da_pkg::ACC_W-1:0]  addend;

    assign addend = mp_reg[f2da_pkg::MP_W-1] ? f2da_pkg::ACC_W'(mc_reg) : '0;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        acc_next  = acc_reg;
        if (cmd.start)
        begin
            cnt_next = cmd.steps;
            mc_next  = multiplicand;
            mp_next  = multiplier;
            acc_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            mp_next   = {mp_reg[f2da_pkg::MP_W-2:0], 1'b0};
            acc_next  = {acc_reg[f2da_pkg::ACC_W-2:0], 1'b0} + addend;
            done_next = (cnt_reg == f2da_pkg::STEP_W'(1));
        end
    end

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // operand and accumulator registers
    always_ff @(posedge clk)
    begin
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        acc_reg <= acc_next;
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

// ===== hw/rtl/fragment_to_disk_address_top.sv =====
// fragment to disk address mapper: top level with sequencer and offset table
//
// A beat is taken when start is high and busy is low. A load beat (operation
// high) writes one slot of the 32-entry offset table and its acknowledge
// appears on the result ports, with done high, in the next cycle; a new beat
// may be started right away. A translate beat keeps busy high while three
// divisions run on one shared restoring divider at one quotient bit per
// cycle (22, 12 and 29 bits) and four products on one shift-add multiplier
// at one bit per cycle (8, 12, 8 and 22 bits), each started when the one
// before it is done. Results are shown for exactly one cycle with done high
// and the receiver cannot stall them. A table slot must be loaded before a
// translation reads it. Geometry registers are written through the cfg port,
// which is always ready, and must only be written while busy is low.
module fragment_to_disk_address_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             operation,
    input  logic [f2da_pkg::FRAG_W-1:0]      frag_index,
    input  logic [f2da_pkg::SLOT_W-1:0]      slot_number,
    input  logic [f2da_pkg::OFS_W-1:0]       slot_offset,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [f2da_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [f2da_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             done,
    output logic [f2da_pkg::LIN_W-1:0]       linear_sector,
    output logic [f2da_pkg::ADDR_OUT_W-1:0]  cylinder_out,
    output logic [f2da_pkg::ADDR_OUT_W-1:0]  head_out,
    output logic [f2da_pkg::SEC_W-1:0]       sector_in_track,
    output logic                             load_done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_CYL,
        ST_DIV_SET,
        ST_MUL_TRS,
        ST_MUL_SET,
        ST_MUL_HDS,
        ST_MUL_CYL,
        ST_DIV_HEAD
    } state_t;

    state_t state_reg, state_next;

    // geometry registers
    logic [f2da_pkg::BPC_W-1:0]  bpc_reg, bpc_next;
    logic [f2da_pkg::BPRS_W-1:0] bprs_reg, bprs_next;
    logic [f2da_pkg::GEO_W-1:0]  spt_reg, spt_next;
    logic [f2da_pkg::GEO_W-1:0]  hds_reg, hds_next;
    logic [f2da_pkg::GEO_W-1:0]  trs_reg, trs_next;

    // per-item working registers
    logic [f2da_pkg::FIB_W-1:0]  fib_reg, fib_next;
    logic [f2da_pkg::CYL_W-1:0]  cyl_reg, cyl_next;
    logic [f2da_pkg::BPC_W-1:0]  rs_reg, rs_next;
    logic [f2da_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [f2da_pkg::CS_W-1:0]   cs_reg, cs_next;

    // registered outputs
    logic                             done_reg, done_next;
    logic [f2da_pkg::LIN_W-1:0]       lin_reg, lin_next;
    logic [f2da_pkg::ADDR_OUT_W-1:0]  cyl_out_reg, cyl_out_next;
    logic [f2da_pkg::ADDR_OUT_W-1:0]  head_reg, head_next;
    logic [f2da_pkg::SEC_W-1:0]       sec_reg, sec_next;
    logic                             ld_reg, ld_next;

    // offset table
    logic [f2da_pkg::OFS_W-1:0] offset_table_mem [f2da_pkg::ROT_SET_SLOTS];
    logic [f2da_pkg::OFS_W-1:0] table_rd_reg;

    // serial units
    f2da_pkg::unit_cmd_t          div_cmd, mul_cmd;
    logic [f2da_pkg::DVD_W-1:0]   div_dvd;
    logic [f2da_pkg::DVS_W-1:0]   div_dvs;
    logic [f2da_pkg::DVD_W-1:0]   div_quo;
    logic [f2da_pkg::DVS_W-1:0]   div_rem;
    logic                         div_done;
    logic [f2da_pkg::MC_W-1:0]    mul_mc;
    logic [f2da_pkg::MP_W-1:0]    mul_mp;
    logic [f2da_pkg::ACC_W-1:0]   mul_acc;
    logic                         mul_done;

    logic                         accept;
    logic                         table_we;
    logic [f2da_pkg::BPC_W-1:0]   bpc_nz;
    logic [f2da_pkg::BPRS_W-1:0]  bprs_nz;
    logic [f2da_pkg::GEO_W-1:0]   spt_nz;
    logic [f2da_pkg::CS_W-1:0]    cs_sum;
    logic [f2da_pkg::LIN_W-1:0]   lin_sum;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign table_we  = accept && (operation == f2da_pkg::OP_LOAD);

    // zero divisors act as one
    assign bpc_nz  = (bpc_reg == '0) ? f2da_pkg::BPC_W'(1) : bpc_reg;
    assign bprs_nz = (bprs_reg == '0) ? f2da_pkg::BPRS_W'(1) : bprs_reg;
    assign spt_nz  = (spt_reg == '0) ? f2da_pkg::GEO_W'(1) : spt_reg;

    // sector offset within the cylinder and the linear sector
    assign cs_sum = mul_acc[f2da_pkg::CS_W-1:0] + f2da_pkg::CS_W'(table_rd_reg)
                  + f2da_pkg::CS_W'(fib_reg) * f2da_pkg::CS_W'(f2da_pkg::SECTORS_PER_FRAGMENT);
    assign lin_sum = f2da_pkg::LIN_W'(mul_acc) + f2da_pkg::LIN_W'(cs_reg);

    f2da_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (div_cmd),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    f2da_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (mul_cmd),
        .multiplicand (mul_mc),
        .multiplier   (mul_mp),
        .product      (mul_acc),
        .done         (mul_done)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        bpc_next     = bpc_reg;
        bprs_next    = bprs_reg;
        spt_next     = spt_reg;
        hds_next     = hds_reg;
        trs_next     = trs_reg;
        fib_next     = fib_reg;
        cyl_next     = cyl_reg;
        rs_next      = rs_reg;
        slot_next    = slot_reg;
        cs_next      = cs_reg;
        done_next    = 1'b0;
        lin_next     = lin_reg;
        cyl_out_next = cyl_out_reg;
        head_next    = head_reg;
        sec_next     = sec_reg;
        ld_next      = ld_reg;
        div_cmd      = '0;
        mul_cmd      = '0;
        div_dvd      = '0;
        div_dvs      = '0;
        mul_mc       = '0;
        mul_mp       = '0;

        // configuration writes
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                f2da_pkg::REG_BPC:  bpc_next  = cfg_data[f2da_pkg::BPC_W-1:0];
                f2da_pkg::REG_BPRS: bprs_next = cfg_data[f2da_pkg::BPRS_W-1:0];
                f2da_pkg::REG_SPT:  spt_next  = cfg_data[f2da_pkg::GEO_W-1:0];
                f2da_pkg::REG_HDS:  hds_next  = cfg_data[f2da_pkg::GEO_W-1:0];
                f2da_pkg::REG_TRS:  trs_next  = cfg_data[f2da_pkg::GEO_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (table_we)
                begin
                    // load acknowledge
                    done_next    = 1'b1;
                    ld_next      = 1'b1;
                    lin_next     = '0;
                    cyl_out_next = '0;
                    head_next    = '0;
                    sec_next     = '0;
                end
                else if (accept)
                begin
                    // block / blocks_per_cylinder
                    fib_next      = frag_index[f2da_pkg::FIB_W-1:0];
                    div_cmd.start = 1'b1;
                    div_cmd.steps = f2da_pkg::STEP_W'(f2da_pkg::BLOCK_W);
                    div_dvd       = {frag_index[f2da_pkg::FRAG_W-1:f2da_pkg::FIB_W],
                                     (f2da_pkg::DVD_W - f2da_pkg::BLOCK_W)'(0)};
                    div_dvs       = bpc_nz;
                    state_next    = ST_DIV_CYL;
                end
            end
            ST_DIV_CYL:
            begin
                if (div_done)
                begin
                    // block in cylinder / blocks_per_rot_set
                    cyl_next      = div_quo[f2da_pkg::CYL_W-1:0];
                    div_cmd.start = 1'b1;
                    div_cmd.steps = f2da_pkg::STEP_W'(f2da_pkg::BPC_W);
                    div_dvd       = {div_rem, (f2da_pkg::DVD_W - f2da_pkg::BPC_W)'(0)};
                    div_dvs       = f2da_pkg::DVS_W'(bprs_nz);
                    state_next    = ST_DIV_SET;
                end
            end
            ST_DIV_SET:
            begin
                if (div_done)
                begin
                    // rotational set and slot, then spt * tracks_per_rot_set
                    rs_next       = div_quo[f2da_pkg::BPC_W-1:0];
                    slot_next     = div_rem[f2da_pkg::SLOT_W-1:0];
                    mul_cmd.start = 1'b1;
                    mul_cmd.steps = f2da_pkg::STEP_W'(f2da_pkg::GEO_W);
                    mul_mc        = f2da_pkg::MC_W'(spt_reg);
                    mul_mp        = {trs_reg, (f2da_pkg::MP_W - f2da_pkg::GEO_W)'(0)};
                    state_next    = ST_MUL_TRS;
                end
            end
            ST_MUL_TRS:
            begin
                if (mul_done)
                begin
                    // times the rotational set
                    mul_cmd.start = 1'b1;
                    mul_cmd.steps = f2da_pkg::STEP_W'(f2da_pkg::BPC_W);
                    mul_mc        = mul_acc[f2da_pkg::MC_W-1:0];
                    mul_mp        = {rs_reg, (f2da_pkg::MP_W - f2da_pkg::BPC_W)'(0)};
                    state_next    = ST_MUL_SET;
                end
            end
            ST_MUL_SET:
            begin
                if (mul_done)
                begin
                    // add slot offset and fragment, then spt * head_count
                    cs_next       = cs_sum;
                    mul_cmd.start = 1'b1;
                    mul_cmd.steps = f2da_pkg::STEP_W'(f2da_pkg::GEO_W);
                    mul_mc        = f2da_pkg::MC_W'(spt_reg);
                    mul_mp        = {hds_reg, (f2da_pkg::MP_W - f2da_pkg::GEO_W)'(0)};
                    state_next    = ST_MUL_HDS;
                end
            end
            ST_MUL_HDS:
            begin
                if (mul_done)
                begin
                    // times the cylinder
                    mul_cmd.start = 1'b1;
                    mul_cmd.steps = f2da_pkg::STEP_W'(f2da_pkg::CYL_W);
                    mul_mc        = mul_acc[f2da_pkg::MC_W-1:0];
                    mul_mp        = cyl_reg;
                    state_next    = ST_MUL_CYL;
                end
            end
            ST_MUL_CYL:
            begin
                if (mul_done)
                begin
                    // linear sector, then sector in cylinder / spt
                    lin_next      = lin_sum;
                    cyl_out_next  = f2da_pkg::ADDR_OUT_W'(cyl_reg);
                    div_cmd.start = 1'b1;
                    div_cmd.steps = f2da_pkg::STEP_W'(f2da_pkg::CS_W);
                    div_dvd       = cs_reg;
                    div_dvs       = f2da_pkg::DVS_W'(spt_nz);
                    state_next    = ST_DIV_HEAD;
                end
            end
            ST_DIV_HEAD:
            begin
                if (div_done)
                begin
                    head_next  = div_quo[f2da_pkg::ADDR_OUT_W-1:0];
                    sec_next   = div_rem[f2da_pkg::SEC_W-1:0];
                    ld_next    = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, configuration, working registers and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bpc_reg     <= f2da_pkg::BPC_W'(1);
            bprs_reg    <= f2da_pkg::BPRS_W'(1);
            spt_reg     <= f2da_pkg::GEO_W'(1);
            hds_reg     <= f2da_pkg::GEO_W'(1);
            trs_reg     <= f2da_pkg::GEO_W'(1);
            fib_reg     <= '0;
            cyl_reg     <= '0;
            rs_reg      <= '0;
            slot_reg    <= '0;
            cs_reg      <= '0;
            done_reg    <= 1'b0;
            lin_reg     <= '0;
            cyl_out_reg <= '0;
            head_reg    <= '0;
            sec_reg     <= '0;
            ld_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bpc_reg     <= bpc_next;
            bprs_reg    <= bprs_next;
            spt_reg     <= spt_next;
            hds_reg     <= hds_next;
            trs_reg     <= trs_next;
            fib_reg     <= fib_next;
            cyl_reg     <= cyl_next;
            rs_reg      <= rs_next;
            slot_reg    <= slot_next;
            cs_reg      <= cs_next;
            done_reg    <= done_next;
            lin_reg     <= lin_next;
            cyl_out_reg <= cyl_out_next;
            head_reg    <= head_next;
            sec_reg     <= sec_next;
            ld_reg      <= ld_next;
        end
    end

    // offset table write port and registered read port
    always_ff @(posedge clk)
    begin
        if (table_we)
        begin
            offset_table_mem[slot_number] <= slot_offset;
        end
        table_rd_reg <= offset_table_mem[slot_reg];
    end

    assign done            = done_reg;
    assign linear_sector   = lin_reg;
    assign cylinder_out    = cyl_out_reg;
    assign head_out        = head_reg;
    assign sector_in_track = sec_reg;
    assign load_done       = ld_reg;

endmodule

// ===== hw/rtl/f2da_checker.sv =====
// port-level checks for the fragment address mapper, bound to the top level
module f2da_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             operation,
    input  logic [f2da_pkg::FRAG_W-1:0]      frag_index,
    input  logic [f2da_pkg::SLOT_W-1:0]      slot_number,
    input  logic [f2da_pkg::OFS_W-1:0]       slot_offset,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [f2da_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [f2da_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             done,
    input  logic [f2da_pkg::LIN_W-1:0]       linear_sector,
    input  logic [f2da_pkg::ADDR_OUT_W-1:0]  cylinder_out,
    input  logic [f2da_pkg::ADDR_OUT_W-1:0]  head_out,
    input  logic [f2da_pkg::SEC_W-1:0]       sector_in_track,
    input  logic                             load_done
);

    // a load beat is acknowledged in the very next cycle
    a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == f2da_pkg::OP_LOAD) |=> (done && load_done))
        else $error("load beat not acknowledged in the next cycle");

    // a translate beat makes the block busy
    a_xlate_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == f2da_pkg::OP_TRANSLATE) |=> (busy && !done))
        else $error("translate beat did not raise busy");

    // results only come out once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // a load acknowledge carries zero address fields
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && load_done) |-> (linear_sector == '0 && cylinder_out == '0
                                 && head_out == '0 && sector_in_track == '0))
        else $error("load acknowledge with nonzero address fields");

endmodule

bind fragment_to_disk_address_top f2da_checker u_f2da_checker (.*);
